/* hw/rtl/mwd_pkg.sv */
// Shared types and codes of the multiword integer divider.
package mwd_pkg;

  // Width of the value and kind fields on the stream ports.
  localparam int VALUE_W = 32;
  localparam int KIND_W  = 2;

  // Input command codes, carried in in_tuser.
  localparam logic CMD_DIVIDEND = 1'b0;
  localparam logic CMD_DIVISOR  = 1'b1;

  // Result kinds, carried in out_tuser.
  localparam logic [KIND_W-1:0] KIND_QUO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REM = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR = 2'd2;

  // Control of the remainder unit for one cycle.
  typedef struct packed {
    logic start;  // begin a new division: remainder reads as zero
    logic step;   // process one remainder digit
    logic first;  // this digit is the lowest one of a pass
    logic last;   // this digit is the highest one of a pass
  } rem_ctl_t;

endpackage

/* hw/rtl/multiword_integer_divider_top.sv */
// Top level of the multiword unsigned integer divider.
//
// Operands load one digit per request, dividend first, then divisor; the
// flagged last divisor digit starts a restoring binary long division. The
// remainder is kept digit by digit and one DIGIT_BITS-wide subtractor works
// through it one digit per cycle, so each dividend bit takes one pass over
// the sb+1 remainder digits for a divisor of sb digits. Once an sa-digit
// dividend has been divided, its sa+1 result digits leave at one per cycle
// while the output side keeps up (quotient digits first, then remainder,
// least significant first). A zero divisor or one longer than the dividend
// yields a single error result, loaded after the check state once the
// output register is free. New operand digits are taken again once the
// last result of a division has entered the output register.
module multiword_integer_divider_top #(
  parameter int DIGIT_BITS = 32,
  parameter int MAX_DIGITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // digit[31:0]
  input  logic                        in_tuser,   // cmd[0]
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,  // value[31:0]
  output logic [1:0]                  out_tuser,  // kind[1:0]
  output logic                        out_tlast
);

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int SW = $clog2(MAX_DIGITS);
  localparam int BW = $clog2(DIGIT_BITS);
  localparam int VW = mwd_pkg::VALUE_W;
  localparam int KW = mwd_pkg::KIND_W;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_ERR   = 3'd2;
  localparam logic [2:0] ST_FETCH = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_EMITQ = 3'd5;
  localparam logic [2:0] ST_EMITR = 3'd6;

  // Operand stores; the dividend store receives the quotient in place.
  logic [DIGIT_BITS-1:0] dstore_r [MAX_DIGITS];
  logic [DIGIT_BITS-1:0] vstore_r [MAX_DIGITS];

  logic [2:0]            state_r, state_nxt;
  logic [CW-1:0]         dcount_r, dcount_nxt;
  logic [CW-1:0]         vcount_r, vcount_nxt;
  logic                  nonzero_r, nonzero_nxt;
  logic [CW-1:0]         k_r, k_nxt;
  logic [SW-1:0]         di_r, di_nxt;
  logic [BW-1:0]         bit_r, bit_nxt;
  logic [DIGIT_BITS-1:0] qd_r, qd_nxt;

  logic                  out_valid_r;
  logic [KW-1:0]         out_kind_r;
  logic [VW-1:0]         out_value_r;
  logic                  out_last_r;

  logic                  load_out;
  logic [KW-1:0]         load_kind;
  logic [VW-1:0]         load_value;
  logic                  load_last;

  logic                  dstore_we;
  logic [SW-1:0]         dstore_wa;
  logic [DIGIT_BITS-1:0] dstore_wd;
  logic                  vstore_we;

  logic                  in_fire;
  logic                  out_free;
  logic [DIGIT_BITS-1:0] in_digit;
  logic [DIGIT_BITS-1:0] dvs_digit;
  logic [DIGIT_BITS-1:0] qd_shift;
  logic [DIGIT_BITS-1:0] rem_digit;
  logic                  borrow;
  mwd_pkg::rem_ctl_t     rem_ctl;

  assign in_tready = (state_r == ST_LOAD);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign in_digit  = DIGIT_BITS'(in_tdata);
  assign dvs_digit = (k_r < vcount_r) ? vstore_r[k_r[SW-1:0]] : '0;
  // Quotient bit enters at the bottom while the dividend bit leaves the top.
  assign qd_shift  = {qd_r[DIGIT_BITS-2:0], ~borrow};

  mwd_rem_unit #(
    .DIGIT_BITS(DIGIT_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rem_ctl),
    .idx       (k_r),
    .lo_bit    (qd_r[DIGIT_BITS-1]),
    .dvs_digit (dvs_digit),
    .borrow_out(borrow),
    .rd_digit  (rem_digit)
  );

  always_comb begin
    state_nxt   = state_r;
    dcount_nxt  = dcount_r;
    vcount_nxt  = vcount_r;
    nonzero_nxt = nonzero_r;
    k_nxt       = k_r;
    di_nxt      = di_r;
    bit_nxt     = bit_r;
    qd_nxt      = qd_r;
    rem_ctl     = '0;
    load_out    = 1'b0;
    load_kind   = mwd_pkg::KIND_QUO;
    load_value  = '0;
    load_last   = 1'b0;
    dstore_we   = 1'b0;
    dstore_wa   = dcount_r[SW-1:0];
    dstore_wd   = in_digit;
    vstore_we   = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (in_tuser == mwd_pkg::CMD_DIVIDEND) begin
            if (dcount_r < CW'(MAX_DIGITS)) begin
              dstore_we  = 1'b1;
              dcount_nxt = dcount_r + CW'(1);
            end
          end else begin
            if (vcount_r < CW'(MAX_DIGITS)) begin
              vstore_we   = 1'b1;
              vcount_nxt  = vcount_r + CW'(1);
              nonzero_nxt = nonzero_r || (in_digit != '0);
            end
            if (in_tlast) begin
              state_nxt = ST_CHECK;
            end
          end
        end
      end
      ST_CHECK: begin
        if (!nonzero_r || (vcount_r > dcount_r)) begin
          state_nxt = ST_ERR;
        end else begin
          rem_ctl.start = 1'b1;
          di_nxt        = SW'(dcount_r - CW'(1));
          bit_nxt       = '0;
          k_nxt         = '0;
          state_nxt     = ST_FETCH;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          load_out    = 1'b1;
          load_kind   = mwd_pkg::KIND_ERR;
          load_value  = '0;
          load_last   = 1'b1;
          dcount_nxt  = '0;
          vcount_nxt  = '0;
          nonzero_nxt = 1'b0;
          state_nxt   = ST_LOAD;
        end
      end
      ST_FETCH: begin
        qd_nxt    = dstore_r[di_r];
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_ctl.step  = 1'b1;
        rem_ctl.first = (k_r == '0);
        rem_ctl.last  = (k_r == vcount_r);
        if (k_r == vcount_r) begin
          k_nxt  = '0;
          qd_nxt = qd_shift;
          if (bit_r == BW'(DIGIT_BITS - 1)) begin
            bit_nxt   = '0;
            dstore_we = 1'b1;
            dstore_wa = di_r;
            dstore_wd = qd_shift;
            if (di_r == '0) begin
              state_nxt = ST_EMITQ;
            end else begin
              di_nxt    = di_r - SW'(1);
              state_nxt = ST_FETCH;
            end
          end else begin
            bit_nxt = bit_r + BW'(1);
          end
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      ST_EMITQ: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_kind  = mwd_pkg::KIND_QUO;
          load_value = VW'(dstore_r[k_r[SW-1:0]]);
          if (k_r == dcount_r - vcount_r) begin
            k_nxt     = '0;
            state_nxt = ST_EMITR;
          end else begin
            k_nxt = k_r + CW'(1);
          end
        end
      end
      ST_EMITR: begin
        if (out_free) begin
          load_out   = 1'b1;
          load_kind  = mwd_pkg::KIND_REM;
          load_value = VW'(rem_digit);
          load_last  = (k_r == vcount_r - CW'(1));
          if (k_r == vcount_r - CW'(1)) begin
            k_nxt       = '0;
            dcount_nxt  = '0;
            vcount_nxt  = '0;
            nonzero_nxt = 1'b0;
            state_nxt   = ST_LOAD;
          end else begin
            k_nxt = k_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      dcount_r    <= '0;
      vcount_r    <= '0;
      nonzero_r   <= 1'b0;
      k_r         <= '0;
      di_r        <= '0;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dcount_r  <= dcount_nxt;
      vcount_r  <= vcount_nxt;
      nonzero_r <= nonzero_nxt;
      k_r       <= k_nxt;
      di_r      <= di_nxt;
      bit_r     <= bit_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    qd_r <= qd_nxt;
    if (load_out) begin
      out_kind_r  <= load_kind;
      out_value_r <= load_value;
      out_last_r  <= load_last;
    end
    if (dstore_we) begin
      dstore_r[dstore_wa] <= dstore_wd;
    end
    if (vstore_we) begin
      vstore_r[vcount_r[SW-1:0]] <= in_digit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // An error result is a single flagged item with a zero value.
  a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == mwd_pkg::KIND_ERR) |-> (out_tdata == '0 && out_tlast))
    else $error("error result carries data or lacks the final flag");

  // Operand counts saturate at the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (dcount_r <= CW'(MAX_DIGITS)) && (vcount_r <= CW'(MAX_DIGITS)))
    else $error("operand count beyond store depth");

  // The digit index of a pass never runs past the top remainder digit.
  a_pass_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (k_r <= vcount_r))
    else $error("remainder digit index past the pass length");

  // Both counts are cleared once the last remainder digit is handed over.
  a_counts_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMITR && out_free && k_r == vcount_r - CW'(1))
      |=> (dcount_r == '0 && vcount_r == '0 && in_tready))
    else $error("counts not cleared after a division");

endmodule

/* hw/rtl/mwd_rem_unit.sv */
// Partial remainder store with one digit-wide shift-and-subtract slice.
module mwd_rem_unit #(
  parameter int DIGIT_BITS = 32,
  parameter int MAX_DIGITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mwd_pkg::rem_ctl_t                  ctl,
  input  logic [$clog2(MAX_DIGITS+1)-1:0]    idx,
  input  logic                               lo_bit,
  input  logic [DIGIT_BITS-1:0]              dvs_digit,
  output logic                               borrow_out,
  output logic [DIGIT_BITS-1:0]              rd_digit
);

  localparam int DEPTH = MAX_DIGITS + 1;

  // Two buffers: one holds the shifted remainder, the other the shifted
  // remainder minus the divisor. The pass end picks one by flipping cur_r.
  logic [DIGIT_BITS-1:0] rema_r [DEPTH];
  logic [DIGIT_BITS-1:0] remb_r [DEPTH];
  logic                  cur_r;
  logic                  fresh_r;
  logic                  msb_r;
  logic                  borrow_r;

  logic [DIGIT_BITS-1:0] cur_digit;
  logic [DIGIT_BITS-1:0] x_digit;
  logic [DIGIT_BITS-1:0] sh_digit;
  logic [DIGIT_BITS-1:0] diff_digit;
  logic                  lo;
  logic [DIGIT_BITS:0]   sub;

  assign cur_digit  = cur_r ? remb_r[idx] : rema_r[idx];
  assign x_digit    = fresh_r ? '0 : cur_digit;
  assign lo         = ctl.first ? lo_bit : msb_r;
  assign sh_digit   = {x_digit[DIGIT_BITS-2:0], lo};
  assign sub        = {1'b0, sh_digit} - {1'b0, dvs_digit} - {{DIGIT_BITS{1'b0}}, borrow_r};
  assign diff_digit = sub[DIGIT_BITS-1:0];
  assign borrow_out = sub[DIGIT_BITS];
  assign rd_digit   = cur_digit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= 1'b0;
      fresh_r  <= 1'b0;
      msb_r    <= 1'b0;
      borrow_r <= 1'b0;
    end else if (ctl.start) begin
      fresh_r  <= 1'b1;
      borrow_r <= 1'b0;
    end else if (ctl.step) begin
      msb_r <= x_digit[DIGIT_BITS-1];
      if (ctl.last) begin
        borrow_r <= 1'b0;
        fresh_r  <= 1'b0;
        // No borrow out of the top digit means remainder >= divisor.
        if (!borrow_out) begin
          cur_r <= ~cur_r;
        end
      end else begin
        borrow_r <= borrow_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      rema_r[idx] <= cur_r ? diff_digit : sh_digit;
      remb_r[idx] <= cur_r ? sh_digit : diff_digit;
    end
  end

endmodule

/* dv/tb.sv */
// Self-checking testbench for the multiword integer divider top level.
module tb;

  localparam int DW           = 32;
  localparam int MAX_DIGITS   = 16;
  localparam int N_REQUESTS   = 350;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [mwd_pkg::KIND_W-1:0]  kind;
    logic [mwd_pkg::VALUE_W-1:0] value;
    logic                        fin;
  } result_digit_t;

  // Keeps its own copy of both operand stores and predicts the quotient and
  // remainder digits, or the error result, of every division that a flagged divisor digit starts.
  class long_division_model;
    logic [DW-1:0] dividend_digits [MAX_DIGITS];
    logic [DW-1:0] divisor_digits [MAX_DIGITS];
    int            n_dividend;
    int            n_divisor;
    result_digit_t awaited [$];
    int            mismatches;
    int            results_seen;

    function new();
      n_dividend   = 0;
      n_divisor    = 0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void note_request(logic cmd, logic [DW-1:0] digit, logic lst);
      logic [DW*MAX_DIGITS-1:0] num;
      logic [DW*MAX_DIGITS-1:0] den;
      logic [DW*MAX_DIGITS-1:0] quo;
      logic [DW*MAX_DIGITS-1:0] rmd;
      int                       sa;
      int                       sb;
      // Digits past the store depth are dropped; the count stays saturated.
      if (cmd == mwd_pkg::CMD_DIVIDEND) begin
        if (n_dividend < MAX_DIGITS) begin
          dividend_digits[n_dividend] = digit;
          n_dividend++;
        end
        return;
      end
      if (n_divisor < MAX_DIGITS) begin
        divisor_digits[n_divisor] = digit;
        n_divisor++;
      end
      if (!lst) return;
      sa         = n_dividend;
      sb         = n_divisor;
      n_dividend = 0;
      n_divisor  = 0;
      num        = '0;
      den        = '0;
      for (int k = 0; k < sa; k++) num[k*DW +: DW] = dividend_digits[k];
      for (int k = 0; k < sb; k++) den[k*DW +: DW] = divisor_digits[k];
      if (den == '0 || sb > sa) begin
        awaited.push_back('{mwd_pkg::KIND_ERR, '0, 1'b1});
        return;
      end
      quo = num / den;
      rmd = num % den;
      // With zero top divisor digits the quotient can be wider than the
      // digits sent out; only the low sa-sb+1 digits leave the block.
      for (int k = 0; k <= sa - sb; k++)
        awaited.push_back('{mwd_pkg::KIND_QUO, quo[k*DW +: DW], 1'b0});
      for (int k = 0; k < sb; k++)
        awaited.push_back('{mwd_pkg::KIND_REM, rmd[k*DW +: DW], k == sb - 1});
    endfunction

    function void check_result(logic [mwd_pkg::KIND_W-1:0] kind,
                               logic [mwd_pkg::VALUE_W-1:0] value, logic fin);
      result_digit_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: kind %0d value %h last %0b", kind, value, fin);
        return;
      end
      want = awaited.pop_front();
      if (want.kind !== kind || want.value !== value || want.fin !== fin) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d: expected kind %0d value %h last %0b, %s %0d value %h last %0b",
                   results_seen, want.kind, want.value, want.fin, "got kind",
                   kind, value, fin);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [31:0]        in_tdata;
  logic               in_tuser;
  logic               in_tlast;
  logic               out_tvalid;
  logic               out_tready;
  logic [31:0]        out_tdata;
  logic [1:0]         out_tuser;
  logic               out_tlast;

  long_division_model model_h = new();
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 requests_sent;
  int                 cycles = 0;
  bit                 hold_done;
  logic [DW-1:0]      dvd_q [$];
  logic [DW-1:0]      dvs_q [$];

  multiword_integer_divider_top #(
    .DIGIT_BITS(DW),
    .MAX_DIGITS(MAX_DIGITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[multiword_integer_divider_top] ERROR");
      $finish;
    end
  end

  function automatic logic [DW-1:0] pick_digit();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return DW'(1);
      3:       return DW'($urandom_range(255));
      4:       return {1'b1, (DW-1)'($urandom)};
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic send_digit(input logic cmd, input logic [DW-1:0] digit, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      in_tuser  <= 1'($urandom_range(1));
      in_tlast  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= digit;
    in_tuser  <= cmd;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model_h.note_request(cmd, digit, lst);
    requests_sent++;
  endtask

  // A flag on a dividend digit has no effect, so it may be scattered freely.
  task automatic send_operands(input bit loose_last);
    foreach (dvd_q[k])
      send_digit(mwd_pkg::CMD_DIVIDEND, dvd_q[k],
                 (k == dvd_q.size() - 1) || (loose_last && $urandom_range(3) == 0));
    foreach (dvs_q[k])
      send_digit(mwd_pkg::CMD_DIVISOR, dvs_q[k], k == dvs_q.size() - 1);
  endtask

  task automatic random_division();
    int mode;
    int sa;
    int sb;
    int lead;
    mode = $urandom_range(99);
    sa   = (mode < 7) ? 16 + $urandom_range(1) : $urandom_range(1, 4);
    sb   = (mode < 7) ? $urandom_range(1, 17) : $urandom_range(1, sa);
    if (mode >= 7 && mode < 11) sb = sa + $urandom_range(1, 2);
    if (mode >= 11 && mode < 13) sa = 0;
    dvd_q.delete();
    dvs_q.delete();
    repeat (sa) dvd_q.push_back(pick_digit());
    repeat (sb) dvs_q.push_back(pick_digit());
    if (mode >= 13 && mode < 17) begin
      foreach (dvs_q[k]) dvs_q[k] = '0;
    end else if (mode >= 17 && mode < 32) begin
      lead = $urandom_range(1, sb);
      for (int k = sb - lead; k < sb; k++) dvs_q[k] = '0;
    end
    // A stray divisor digit ahead of the dividend still counts toward the divisor.
    if (mode >= 32 && mode < 37) send_digit(mwd_pkg::CMD_DIVISOR, pick_digit(), 1'b0);
    send_operands(mode >= 37 && mode < 50);
  endtask

  // Result side: random back-pressure plus one long hold-off that lets the
  // block fill up while requests keep coming.
  initial begin
    out_tready <= 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        model_h.check_result(out_tuser, out_tdata, out_tlast);
      if (!hold_done && model_h.results_seen >= 30) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    requests_sent = 0;
    send_idle_pct = 22;
    recv_idle_pct = 48;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= mwd_pkg::CMD_DIVIDEND;
    in_tlast  <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dvd_q = '{32'hFFFF_FFFF};
    dvs_q = '{32'd1};
    send_operands(1'b0);
    dvd_q = '{32'd0};
    dvs_q = '{32'hFFFF_FFFF};
    send_operands(1'b0);
    dvd_q = '{32'd5, 32'd7};
    dvs_q = '{32'd0, 32'd0};
    send_operands(1'b0);
    dvd_q = '{32'd9};
    dvs_q = '{32'd1, 32'd2};
    send_operands(1'b0);
    dvd_q.delete();
    dvs_q = '{32'd3};
    send_operands(1'b0);
    dvd_q = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    dvs_q = '{32'h8000_0001, 32'd0, 32'd0};
    send_operands(1'b0);
    send_digit(mwd_pkg::CMD_DIVIDEND, 32'd1, 1'b1);
    send_digit(mwd_pkg::CMD_DIVIDEND, 32'h1234_5678, 1'b0);
    send_digit(mwd_pkg::CMD_DIVIDEND, 32'd3, 1'b1);
    send_digit(mwd_pkg::CMD_DIVISOR, 32'd2, 1'b0);
    send_digit(mwd_pkg::CMD_DIVISOR, 32'd1, 1'b1);

    while (requests_sent < N_REQUESTS) begin
      if (requests_sent < N_REQUESTS / 3) begin
        send_idle_pct = 22;
        recv_idle_pct = 48;
      end else if (requests_sent < 2 * N_REQUESTS / 3) begin
        send_idle_pct = 48;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_division();
    end
    in_tvalid <= 1'b0;

    while (model_h.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (model_h.mismatches == 0 && model_h.awaited.size() == 0) begin
      $display("[multiword_integer_divider_top] OK");
    end else begin
      $display("[multiword_integer_divider_top] ERROR");
    end
    $finish;
  end

endmodule
